FILE: hdl/fnvht_pkg.sv
// shared widths, codes and hash constants for the fnv hash table
`default_nettype none
package fnvht_pkg;

   // field widths of the request and response channels
   localparam int MODE_W   = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 6;
   localparam int COUNT_W  = 7;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // 64-bit fnv-1a: prime is 2^40 + 0x1b3
   localparam logic [KEY_W-1:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
   localparam int               FNV_PRIME_SHIFT = 40;
   localparam logic [8:0]       FNV_PRIME_LOW   = 9'h1B3;

   // hash mod table size is taken one byte per step, msb first
   localparam int MOD_DIGIT_W = 8;
   localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;

endpackage
`default_nettype wire

FILE: hdl/fnvht_if.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none
interface fnvht_req_if;
   logic                            valid;
   logic                            ready;
   logic [fnvht_pkg::MODE_W-1:0]    mode;
   logic [fnvht_pkg::KEY_W-1:0]     key;
   logic [fnvht_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface fnvht_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fnvht_pkg::STATUS_W-1:0]  status;
   logic [fnvht_pkg::VALUE_W-1:0]   found_value;
   logic [fnvht_pkg::SLOT_W-1:0]    slot_index;
   logic [fnvht_pkg::COUNT_W-1:0]   entry_count;

   modport source (output valid, output status, output found_value, output slot_index,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found_value, input slot_index,
                   input entry_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/fnv_linear_probe_hash_table_core.sv
// fnv-1a keyed open addressing hash table with linear probing, one slot memory
// insert/lookup: KEY_BYTES hash steps, 8 mod steps, a start state for the first read,
//   P probes, then the response; P = slots visited (1..TABLE_SIZE, one per cycle)
// throughput: one request in flight; the next is taken once the output register loads
// clear: sweep that zeroes every slot, then response
// reset (sync, high): control cleared, sweep of every slot, no requests until done
`default_nettype none
module fnv_linear_probe_hash_table_core #(
   parameter int TABLE_SIZE = 64,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   fnvht_req_if.sink                        req_ch,
   fnvht_rsp_if.source                      rsp_ch,
   input  wire                              csr_write_en,
   input  wire [fnvht_pkg::LIMIT_W-1:0]     csr_write_data
);

   // slot index and entry count widths follow the table size
   localparam int IW   = $clog2(TABLE_SIZE);
   localparam int CW   = $clog2(TABLE_SIZE + 1);
   localparam int CMPW = (CW > fnvht_pkg::LIMIT_W) ? CW : fnvht_pkg::LIMIT_W;
   // stored value is clipped to the channel width
   localparam int SVW  = (VALUE_BITS < fnvht_pkg::VALUE_W) ? VALUE_BITS : fnvht_pkg::VALUE_W;
   // memory word: {used, hash, value}
   localparam int MW   = 1 + fnvht_pkg::KEY_W + SVW;

   localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_SIZE - 1);
   localparam logic [IW:0]   TABLE_N   = (IW + 1)'(TABLE_SIZE);
   localparam logic [2:0]    LAST_HASH = 3'(KEY_BYTES - 1);
   localparam logic [2:0]    LAST_MOD  = 3'(fnvht_pkg::MOD_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_START,
      ST_PROBE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // one fnv-1a byte step, multiply by 2^40 + 0x1b3 as shift plus narrow product
   function automatic logic [fnvht_pkg::KEY_W-1:0] fnv_step(
      input logic [fnvht_pkg::KEY_W-1:0] h,
      input logic [7:0]                  b
   );
      logic [fnvht_pkg::KEY_W-1:0] x;
      x = h ^ {56'd0, b};
      return (x << fnvht_pkg::FNV_PRIME_SHIFT) + x * 64'(fnvht_pkg::FNV_PRIME_LOW);
   endfunction

   state_type                        state_ff;
   logic [2:0]                       step_ff;
   logic [fnvht_pkg::MODE_W-1:0]     mode_ff;
   logic [fnvht_pkg::KEY_W-1:0]      key_ff;
   logic [SVW-1:0]                   val_ff;
   logic [fnvht_pkg::KEY_W-1:0]      hash_ff;
   logic [fnvht_pkg::KEY_W-1:0]      hash_in;
   logic [fnvht_pkg::KEY_W-1:0]      mod_sh_ff;
   logic [IW-1:0]                    rem_ff;
   logic [IW-1:0]                    rem_in;
   logic [IW-1:0]                    rem_acc;
   logic [IW:0]                      rem_t;
   logic [IW-1:0]                    probe_idx_ff;
   logic [IW-1:0]                    probe_idx_in;
   logic [IW-1:0]                    visit_ff;
   logic [CW-1:0]                    count_ff;
   logic [fnvht_pkg::LIMIT_W-1:0]    limit_ff;
   logic                             clear_pend_ff;

   // result staged until the output register is free
   logic [fnvht_pkg::STATUS_W-1:0]   res_status_ff;
   logic [fnvht_pkg::VALUE_W-1:0]    res_value_ff;
   logic [IW-1:0]                    res_slot_ff;

   // output register
   logic                             rsp_valid_ff;
   logic [fnvht_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [fnvht_pkg::VALUE_W-1:0]    rsp_value_ff;
   logic [fnvht_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [fnvht_pkg::COUNT_W-1:0]    rsp_count_ff;

   // slot memory
   logic [MW-1:0]                    mem_ff [TABLE_SIZE];
   logic [MW-1:0]                    rd_data_ff;
   logic [IW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [MW-1:0]                    wr_data;

   logic                             req_take;
   logic                             rsp_free;
   logic                             slot_used;
   logic [fnvht_pkg::KEY_W-1:0]      slot_hash;
   logic [SVW-1:0]                   slot_value;
   logic                             hit;
   logic                             at_limit;
   logic                             last_visit;
   logic                             insert_wr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found_value = rsp_value_ff;
   assign rsp_ch.slot_index  = rsp_slot_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   assign hash_in = fnv_step(hash_ff, key_ff[7:0]);

   // remainder of the hash by the table size, one byte of the hash per cycle
   always_comb begin
      rem_acc = rem_ff;
      rem_t   = '0;
      for (int i = 0; i < fnvht_pkg::MOD_DIGIT_W; i++) begin
         rem_t = {rem_acc, mod_sh_ff[fnvht_pkg::KEY_W-1-i]};
         if (rem_t >= TABLE_N) begin
            rem_t = rem_t - TABLE_N;
         end
         rem_acc = rem_t[IW-1:0];
      end
      rem_in = rem_acc;
   end

   // linear probe with wrap
   assign probe_idx_in = (probe_idx_ff == LAST_IDX) ? '0 : probe_idx_ff + IW'(1);

   // while probing, read the next slot ahead so one slot is checked each cycle
   assign rd_addr = (state_ff == ST_PROBE) ? probe_idx_in : probe_idx_ff;

   // rd_data_ff holds the slot at probe_idx_ff during the probe state
   assign slot_used  = rd_data_ff[MW-1];
   assign slot_hash  = rd_data_ff[MW-2 -: fnvht_pkg::KEY_W];
   assign slot_value = rd_data_ff[SVW-1:0];

   assign hit        = slot_used && (slot_hash == hash_ff);
   assign at_limit   = CMPW'(count_ff) >= CMPW'(limit_ff);
   assign last_visit = (visit_ff == LAST_IDX);
   assign insert_wr  = (state_ff == ST_PROBE) && (mode_ff == fnvht_pkg::MODE_INSERT) &&
                       !slot_used && !at_limit;

   // sweep writes a cleared used bit, insert writes the new entry
   assign wr_en   = (state_ff == ST_SWEEP) || insert_wr;
   assign wr_data = (state_ff == ST_SWEEP) ? '0 : {1'b1, hash_ff, val_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[probe_idx_ff] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         step_ff       <= '0;
         probe_idx_ff  <= '0;
         visit_ff      <= '0;
         count_ff      <= '0;
         limit_ff      <= fnvht_pkg::LIMIT_RESET;
         clear_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end

         // the done state reloads the output register itself
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  mode_ff       <= req_ch.mode;
                  key_ff        <= req_ch.key;
                  val_ff        <= req_ch.value[SVW-1:0];
                  hash_ff       <= fnvht_pkg::FNV_BASIS;
                  step_ff       <= '0;
                  res_status_ff <= fnvht_pkg::STATUS_OK;
                  res_value_ff  <= '0;
                  res_slot_ff   <= '0;
                  if (req_ch.mode == fnvht_pkg::MODE_INSERT ||
                      req_ch.mode == fnvht_pkg::MODE_LOOKUP) begin
                     state_ff <= ST_HASH;
                  end else if (req_ch.mode == fnvht_pkg::MODE_CLEAR) begin
                     count_ff      <= '0;
                     probe_idx_ff  <= '0;
                     clear_pend_ff <= 1'b1;
                     state_ff      <= ST_SWEEP;
                  end else begin
                     // unknown mode: plain ok response, nothing changes
                     state_ff <= ST_DONE;
                  end
               end
            end

            ST_HASH: begin
               hash_ff <= hash_in;
               key_ff  <= key_ff >> 8;
               if (step_ff == LAST_HASH) begin
                  mod_sh_ff <= hash_in;
                  rem_ff    <= '0;
                  step_ff   <= '0;
                  state_ff  <= ST_MOD;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end

            ST_MOD: begin
               rem_ff    <= rem_in;
               mod_sh_ff <= mod_sh_ff << fnvht_pkg::MOD_DIGIT_W;
               step_ff   <= step_ff + 3'd1;
               if (step_ff == LAST_MOD) begin
                  probe_idx_ff <= rem_in;
                  visit_ff     <= '0;
                  state_ff     <= ST_START;
               end
            end

            ST_START: begin
               // first slot read is in flight
               state_ff <= ST_PROBE;
            end

            ST_PROBE: begin
               if (hit) begin
                  res_status_ff <= (mode_ff == fnvht_pkg::MODE_INSERT) ?
                                   fnvht_pkg::STATUS_DUPLICATE : fnvht_pkg::STATUS_OK;
                  res_value_ff  <= (mode_ff == fnvht_pkg::MODE_LOOKUP) ?
                                   fnvht_pkg::VALUE_W'(slot_value) : '0;
                  res_slot_ff   <= probe_idx_ff;
                  state_ff      <= ST_DONE;
               end else if (!slot_used || last_visit) begin
                  res_value_ff <= '0;
                  if (mode_ff == fnvht_pkg::MODE_INSERT) begin
                     if (insert_wr) begin
                        res_status_ff <= fnvht_pkg::STATUS_OK;
                        res_slot_ff   <= probe_idx_ff;
                        count_ff      <= count_ff + CW'(1);
                     end else begin
                        // entry limit reached or no empty slot anywhere
                        res_status_ff <= fnvht_pkg::STATUS_FULL;
                        res_slot_ff   <= '0;
                     end
                  end else begin
                     res_status_ff <= fnvht_pkg::STATUS_NOT_FOUND;
                     res_slot_ff   <= '0;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  probe_idx_ff <= probe_idx_in;
                  visit_ff     <= visit_ff + IW'(1);
               end
            end

            ST_SWEEP: begin
               probe_idx_ff <= probe_idx_in;
               if (probe_idx_ff == LAST_IDX) begin
                  clear_pend_ff <= 1'b0;
                  state_ff      <= clear_pend_ff ? ST_DONE : ST_IDLE;
               end
            end

            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  rsp_slot_ff   <= fnvht_pkg::SLOT_W'(res_slot_ff);
                  rsp_count_ff  <= fnvht_pkg::COUNT_W'(count_ff);
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
